>>> rtl/one_pole_lowpass_exp_cutoff_assert.svh
// assertion macros for the checker file
`ifndef ONE_POLE_LOWPASS_EXP_CUTOFF_ASSERT_SVH
`define ONE_POLE_LOWPASS_EXP_CUTOFF_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define OPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in one_pole_lowpass_exp_cutoff");

// next-cycle implication, disabled while in reset
`define OPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in one_pole_lowpass_exp_cutoff");

`endif

>>> rtl/oplpf_pkg.sv
package oplpf_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int EXP2_ENTRIES_DEF = 64;

    localparam int KNOB_W      = 17;
    localparam int SR_W        = 20;
    localparam int CV_W        = 24;
    localparam int CV_FRAC     = 18;
    localparam int Y_W         = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int OCT_W       = 26;
    localparam int U_W         = 23;
    localparam int K_W         = 5;
    localparam int TAB_W       = 32;
    localparam int PROD_W      = 57;
    localparam int HZ_RAW_W    = 38;
    localparam int HZ_W        = 36;
    localparam int BND_A_W     = 35;
    localparam int BND_B_W     = 18;
    localparam int DIV_W       = 41;
    localparam int ALPHA_W     = 24;
    localparam int DIV_STEPS   = 24;
    localparam int DIV_CNT_W   = 5;

    localparam logic [SR_W-1:0]    SR_RESET    = 20'd44100;
    localparam logic [24:0]        C4_Q16      = 25'd17145895;
    localparam logic [26:0]        TWO_PI_Q24  = 27'd105414357;
    localparam logic [63:0]        LN2_Q30     = 64'd744261118;
    localparam logic [63:0]        ONE_Q30     = 64'd1 << 30;
    localparam logic signed [OCT_W-1:0] OCT_LOW  = -26'sd2359296;
    localparam logic signed [OCT_W-1:0] OCT_HIGH = 26'sd2883584;
    localparam logic [HZ_W-1:0]    HZ_MIN      = 36'd65536;
    // 0.45 * fs in Q.16 is fs * 147456 / 5 = fs * 29491 + fs / 5
    localparam logic [14:0]        BND_MUL     = 15'd29491;
    localparam logic [19:0]        BND_RECIP   = 20'd838861;
    localparam int                 BND_SHIFT   = 22;
    localparam int                 Y_SHIFT     = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CUTOFF_KNOB  = 2'd0,
        CFG_CV_CONNECTED = 2'd1,
        CFG_SAMPLE_RATE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic load_in;
        logic octave;
        logic interp;
        logic lerp;
        logic scale;
        logic clamp;
        logic omega;
        logic div_step;
        logic upd_mul;
        logic upd_add;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // taylor series of exp(t), t in Q.30
    function automatic logic [63:0] exp2_series(input logic [63:0] t);
        logic [63:0] term;
        logic [63:0] sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * t) >> 30) / 64'(n);
            sum  = sum + term;
        end
        return sum;
    endfunction

endpackage

>>> rtl/oplpf_ctrl.sv
module oplpf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  oplpf_pkg::dp_status_t  status,
    output oplpf_pkg::dp_cmd_t     cmd
);
    import oplpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OCT,
        S_INTERP,
        S_LERP,
        S_SCALE,
        S_CLAMP,
        S_OMEGA,
        S_DIV,
        S_UPD_MUL,
        S_UPD_ADD,
        S_EMIT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_OCT;
                end
            end
            S_OCT:
            begin
                cmd.octave = 1'b1;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_LERP;
            end
            S_LERP:
            begin
                cmd.lerp   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_OMEGA;
            end
            S_OMEGA:
            begin
                cmd.omega  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_UPD_MUL;
                end
            end
            S_UPD_MUL:
            begin
                cmd.upd_mul = 1'b1;
                state_next  = S_UPD_ADD;
            end
            S_UPD_ADD:
            begin
                cmd.upd_add = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/oplpf_dpath.sv
module oplpf_dpath #(
    parameter int SAMPLE_BITS        = oplpf_pkg::SAMPLE_BITS_DEF,
    parameter int EXP2_TABLE_ENTRIES = oplpf_pkg::EXP2_ENTRIES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  oplpf_pkg::dp_cmd_t                     cmd,
    output oplpf_pkg::dp_status_t                  status,
    input  logic                                   cfg_valid,
    input  logic [oplpf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [oplpf_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          sample_in,
    input  logic signed [oplpf_pkg::CV_W-1:0]      cutoff_cv,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]          sample_out
);
    import oplpf_pkg::*;

    localparam int GUARD_BITS = Y_W - SAMPLE_BITS;
    localparam int TAB_IDX_W  = $clog2(EXP2_TABLE_ENTRIES + 1);
    localparam int POS_W      = CV_FRAC + TAB_IDX_W;

    // exponential table, 2^(i/E) in Q2.30
    logic [TAB_W-1:0] exp_tab [0:EXP2_TABLE_ENTRIES];

    for (genvar gi = 0; gi <= EXP2_TABLE_ENTRIES; gi++)
    begin : g_tab
        localparam logic [63:0] T_ARG =
            (64'(gi) * LN2_Q30) / 64'(EXP2_TABLE_ENTRIES);
        if (gi == 0)
        begin : g_first
            assign exp_tab[gi] = TAB_W'(ONE_Q30);
        end
        else if (gi == EXP2_TABLE_ENTRIES)
        begin : g_last
            assign exp_tab[gi] = TAB_W'(ONE_Q30 << 1);
        end
        else
        begin : g_mid
            assign exp_tab[gi] = TAB_W'(exp2_series(T_ARG));
        end
    end

    // configuration
    logic [KNOB_W-1:0] knob_reg;
    logic              cvcon_reg;
    logic [SR_W-1:0]   sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_reg  <= '0;
            cvcon_reg <= 1'b0;
            sr_reg    <= SR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CUTOFF_KNOB:  knob_reg  <= cfg_data[KNOB_W-1:0];
                CFG_CV_CONNECTED: cvcon_reg <= cfg_data[0];
                CFG_SAMPLE_RATE:  sr_reg    <= cfg_data[SR_W-1:0];
                default:          ;
            endcase
        end
    end

    // payload pipeline registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [CV_W-1:0]        cv_reg;
    logic [K_W-1:0]                k_reg;
    logic [CV_FRAC-1:0]            frac_reg;
    logic [CV_FRAC-1:0]            lerp_rem_reg;
    logic [TAB_W-1:0]              lo_reg;
    logic [TAB_W-1:0]              step_reg;
    logic [TAB_W-1:0]              val_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [BND_A_W-1:0]            bnd_a_reg;
    logic [BND_B_W-1:0]            bnd_b_reg;
    logic [HZ_W-1:0]               hz_hi_reg;
    logic [HZ_W-1:0]               hz_reg;
    logic [DIV_W-1:0]              den_reg;
    logic [DIV_W-1:0]              part_reg;
    logic [ALPHA_W-1:0]            alpha_reg;
    logic signed [57:0]            upd_reg;
    logic signed [Y_W-1:0]         y_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    // octave count
    logic signed [OCT_W-1:0] oct_sum;
    logic signed [OCT_W-1:0] oct_clamped;
    logic [U_W-1:0]          oct_u;

    always_comb
    begin
        oct_sum = $signed({7'd0, knob_reg, 2'b00}) + OCT_W'(cv_reg);
        if (oct_sum < OCT_LOW)
        begin
            oct_clamped = OCT_LOW;
        end
        else if (oct_sum > OCT_HIGH)
        begin
            oct_clamped = OCT_HIGH;
        end
        else
        begin
            oct_clamped = oct_sum;
        end
        oct_u = U_W'(oct_clamped - OCT_LOW);
    end

    // table lookup
    logic [POS_W-1:0]     pos;
    logic [TAB_IDX_W-1:0] tab_idx;
    logic [TAB_W-1:0]     tab_lo;
    logic [TAB_W-1:0]     tab_hi;
    logic [39:0]          bnd_b_full;

    assign pos        = POS_W'(frac_reg) * POS_W'(EXP2_TABLE_ENTRIES);
    assign tab_idx    = pos[POS_W-1:CV_FRAC];
    assign tab_lo     = exp_tab[tab_idx];
    assign tab_hi     = exp_tab[tab_idx + 1'b1];
    assign bnd_b_full = 40'(sr_reg) * 40'(BND_RECIP);

    // interpolation and scaling
    logic [49:0]       lerp_prod;
    logic [PROD_W-1:0] scale_prod;

    assign lerp_prod  = 50'(step_reg) * 50'(lerp_rem_reg);
    assign scale_prod = PROD_W'(val_reg) * PROD_W'(C4_Q16);

    // octave shift and cutoff clamp
    logic [5:0]          hz_shift;
    logic [HZ_RAW_W-1:0] hz_raw;
    logic [HZ_RAW_W-1:0] hz_upper;
    logic [HZ_W-1:0]     hz_clamped;

    always_comb
    begin
        hz_shift = 6'd39 - 6'(k_reg);
        hz_raw   = HZ_RAW_W'(prod_reg >> hz_shift);
        if (hz_raw > HZ_RAW_W'(hz_hi_reg))
        begin
            hz_upper = HZ_RAW_W'(hz_hi_reg);
        end
        else
        begin
            hz_upper = hz_raw;
        end
        if (hz_upper < HZ_RAW_W'(HZ_MIN))
        begin
            hz_clamped = HZ_MIN;
        end
        else
        begin
            hz_clamped = HZ_W'(hz_upper);
        end
    end

    // angular frequency and divider
    logic [62:0]      w_full;
    logic [DIV_W-1:0] w_val;
    logic [DIV_W-1:0] part_shl;
    logic             part_ge;

    assign w_full   = 63'(hz_reg) * 63'(TWO_PI_Q24);
    assign w_val    = DIV_W'(w_full[62:24]);
    assign part_shl = {part_reg[DIV_W-2:0], 1'b0};
    assign part_ge  = (part_shl >= den_reg);

    // filter update
    logic signed [Y_W-1:0]  x_wide;
    logic signed [Y_W:0]    diff;
    logic signed [ALPHA_W:0] alpha_s;
    logic signed [57:0]     upd_prod;

    assign x_wide   = Y_W'(x_reg) <<< GUARD_BITS;
    assign diff     = (Y_W + 1)'(x_wide) - (Y_W + 1)'(y_reg);
    assign alpha_s  = $signed({1'b0, alpha_reg});
    assign upd_prod = diff * alpha_s;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg  <= sample_in;
            cv_reg <= cvcon_reg ? cutoff_cv : '0;
        end
        if (cmd.octave)
        begin
            k_reg     <= oct_u[U_W-1:CV_FRAC];
            frac_reg  <= oct_u[CV_FRAC-1:0];
            bnd_a_reg <= BND_A_W'(sr_reg) * BND_A_W'(BND_MUL);
        end
        if (cmd.interp)
        begin
            lo_reg       <= tab_lo;
            step_reg     <= (tab_hi >= tab_lo) ? tab_hi - tab_lo : '0;
            lerp_rem_reg <= pos[CV_FRAC-1:0];
            bnd_b_reg    <= bnd_b_full[BND_SHIFT +: BND_B_W];
        end
        if (cmd.lerp)
        begin
            val_reg   <= lo_reg + TAB_W'(lerp_prod >> CV_FRAC);
            hz_hi_reg <= HZ_W'(bnd_a_reg) + HZ_W'(bnd_b_reg);
        end
        if (cmd.scale)
        begin
            prod_reg <= scale_prod;
        end
        if (cmd.clamp)
        begin
            hz_reg <= hz_clamped;
        end
        if (cmd.omega)
        begin
            part_reg  <= w_val;
            den_reg   <= w_val + DIV_W'({sr_reg, 16'd0});
            alpha_reg <= '0;
        end
        if (cmd.div_step)
        begin
            part_reg  <= part_ge ? part_shl - den_reg : part_shl;
            alpha_reg <= {alpha_reg[ALPHA_W-2:0], part_ge};
        end
        if (cmd.upd_mul)
        begin
            upd_reg <= upd_prod;
        end
        if (cmd.emit)
        begin
            sample_out_reg <= y_reg[Y_W-1 -: SAMPLE_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_add)
            begin
                y_reg <= y_reg + Y_W'(upd_reg >>> Y_SHIFT);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;

endmodule

>>> rtl/one_pole_lowpass_exp_cutoff.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   sample_in, cutoff_cv
// out       output     out_valid / out_stall sample_out
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// each accepted item runs through the 24-step restoring divider that forms alpha
// plus nine sequencer steps before its result enters the output register
// the next item is accepted the cycle after the result enters the output register
// a stalled output holds the sequencer in its last step until taken
// rst_n clears filter state, output valid, knob and cv flag and sets rate to 44100
module one_pole_lowpass_exp_cutoff #(
    parameter int SAMPLE_BITS        = oplpf_pkg::SAMPLE_BITS_DEF,
    parameter int EXP2_TABLE_ENTRIES = oplpf_pkg::EXP2_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  logic signed [oplpf_pkg::CV_W-1:0] cutoff_cv,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     sample_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oplpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [oplpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import oplpf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    oplpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    oplpf_dpath #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .EXP2_TABLE_ENTRIES (EXP2_TABLE_ENTRIES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .cutoff_cv  (cutoff_cv),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

>>> rtl/oplpf_checker.sv
`include "one_pole_lowpass_exp_cutoff_assert.svh"

module oplpf_checker #(
    parameter int SAMPLE_BITS = oplpf_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample_out
);

    // a stalled result stays put
    `OPL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sample_out))

    // an accepted item keeps the block busy for the following cycles
    `OPL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall ##1 in_stall)

    // a result taken while idle is not followed by another
    `OPL_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid && !out_stall && !in_stall, !out_valid)

    // the block frees up only with a result on offer
    `OPL_ASSERT_NOW(a_no_overlap, clk, rst_n, $fell(in_stall), out_valid)

endmodule

bind one_pole_lowpass_exp_cutoff oplpf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

>>> bench/tb_one_pole_lowpass_exp_cutoff.sv
typedef longint unsigned u64_t;
typedef logic signed [oplpf_pkg::SAMPLE_BITS_DEF-1:0] smp_t;
typedef logic signed [oplpf_pkg::CV_W-1:0] cv_t;

class filter_tracker;
    localparam int ENTRIES = oplpf_pkg::EXP2_ENTRIES_DEF;
    localparam int FRAC = 18;
    localparam int GUARD = 32 - oplpf_pkg::SAMPLE_BITS_DEF;
    localparam u64_t C4_HZ = 64'd17145895;
    localparam u64_t TWO_PI = 64'd105414357;
    localparam u64_t LN2 = 64'd744261118;
    localparam u64_t ONE = 64'd1 << 30;
    localparam u64_t ALPHA_TOP = 64'hFFFFFF;
    localparam longint OCT_FLOOR = -(64'sd9 <<< FRAC);
    localparam longint OCT_CEIL = 64'sd11 <<< FRAC;
    localparam longint OUT_HI = (64'sd1 <<< (oplpf_pkg::SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint OUT_LO = -OUT_HI - 1;

    u64_t exp_tab[ENTRIES + 1];
    logic [oplpf_pkg::KNOB_W-1:0] knob;
    logic cv_on;
    logic [oplpf_pkg::SR_W-1:0] rate;
    longint y_state;
    smp_t expected_out[$];
    int errors;
    int matched;
    int writes;

    function new();
        u64_t t;
        u64_t term;
        u64_t sum;
        for (int i = 0; i <= ENTRIES; i++)
        begin
            t = (u64_t'(i) * LN2) / ENTRIES;
            term = ONE;
            sum = ONE;
            for (int n = 1; n <= 14; n++)
            begin
                term = ((term * t) >> 30) / u64_t'(n);
                sum = sum + term;
            end
            exp_tab[i] = sum;
        end
        exp_tab[0] = ONE;
        exp_tab[ENTRIES] = 2 * ONE;
        knob = '0;
        cv_on = 1'b0;
        rate = oplpf_pkg::SR_RESET;
        y_state = 0;
        errors = 0;
        matched = 0;
        writes = 0;
    endfunction

    function void write_reg(logic [oplpf_pkg::CFG_INDEX_W-1:0] idx,
                            logic [oplpf_pkg::CFG_DATA_W-1:0] data);
        writes++;
        case (idx)
            oplpf_pkg::CFG_CUTOFF_KNOB:  knob = data[oplpf_pkg::KNOB_W-1:0];
            oplpf_pkg::CFG_CV_CONNECTED: cv_on = data[0];
            oplpf_pkg::CFG_SAMPLE_RATE:  rate = data[oplpf_pkg::SR_W-1:0];
            default: ;
        endcase
    endfunction

    function u64_t cutoff_alpha(longint cv);
        longint oct;
        u64_t u, frac, pos, idx, rem, lo, hi, val, hz, hz_top, w, den, a, fs;
        int k;
        oct = longint'({knob, 2'b00}) + cv;
        if (oct < OCT_FLOOR) oct = OCT_FLOOR;
        if (oct > OCT_CEIL) oct = OCT_CEIL;
        u = u64_t'(oct - OCT_FLOOR);
        k = int'(u >> FRAC);
        frac = u & ((u64_t'(1) << FRAC) - 1);
        pos = frac * ENTRIES;
        idx = pos >> FRAC;
        rem = pos & ((u64_t'(1) << FRAC) - 1);
        if (idx >= ENTRIES)
        begin
            idx = ENTRIES - 1;
            rem = u64_t'(1) << FRAC;
        end
        lo = exp_tab[idx];
        hi = exp_tab[idx + 1];
        val = (hi >= lo) ? lo + (((hi - lo) * rem) >> FRAC) : lo;
        hz = (C4_HZ * val) >> (39 - k);
        fs = u64_t'(rate);
        hz_top = ((fs * 9) << 16) / 20;
        if (hz > hz_top) hz = hz_top;
        if (hz < (u64_t'(1) << 16)) hz = u64_t'(1) << 16;
        w = (hz * TWO_PI) >> 24;
        den = w + (fs << 16);
        a = (den != 0) ? ((w << 24) / den) : ALPHA_TOP;
        if (a > ALPHA_TOP) a = ALPHA_TOP;
        return a;
    endfunction

    function void take_sample(smp_t s, cv_t c);
        longint x;
        longint o;
        u64_t a;
        a = cutoff_alpha(cv_on ? longint'(c) : 64'sd0);
        x = longint'(s) <<< GUARD;
        y_state = y_state + (((x - y_state) * longint'(a)) >>> 24);
        o = y_state >>> GUARD;
        if (o > OUT_HI) o = OUT_HI;
        if (o < OUT_LO) o = OUT_LO;
        expected_out.push_back(smp_t'(o));
    endfunction

    function void check_out(smp_t got);
        smp_t want;
        if (expected_out.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected output transaction: got %0d", got);
            return;
        end
        want = expected_out.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("sample_out mismatch at output %0d: expected %0d, got %0d",
                         matched + errors, want, got);
        end
        else
            matched++;
    endfunction

    function int pending();
        return expected_out.size();
    endfunction
endclass

module tb_one_pole_lowpass_exp_cutoff;
    import oplpf_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 75;
    localparam int VOLT = 262144;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam smp_t SMP_HI = 24'sh7FFFFF;
    localparam smp_t SMP_LO = 24'sh800000;
    localparam cv_t CV_HI = 24'sh7FFFFF;
    localparam cv_t CV_LO = 24'sh800000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    smp_t sample_in = '0;
    cv_t cutoff_cv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    smp_t sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    filter_tracker tracker = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int quiet = 0;
    int sent = 0;
    logic [CFG_DATA_W-1:0] knob_set[PHASES];
    logic [CFG_DATA_W-1:0] cv_set[PHASES];
    logic [CFG_DATA_W-1:0] rate_set[PHASES];

    one_pole_lowpass_exp_cutoff dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .cutoff_cv(cutoff_cv),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (in_valid && !in_stall)
                tracker.take_sample(sample_in, cutoff_cv);
            if (out_valid && !out_stall)
                tracker.check_out(sample_out);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (quiet >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver side, long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(99) < stall_pct);
    end

    task automatic send_sample(input smp_t s, input cv_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample_in = s;
        cutoff_cv = c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_rates(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    function automatic smp_t rand_sample();
        case ($urandom_range(5))
            0: return SMP_HI;
            1: return SMP_LO;
            2: return smp_t'(int'($urandom_range(2000)) - 1000);
            default: return smp_t'($urandom);
        endcase
    endfunction

    function automatic cv_t rand_cv();
        case ($urandom_range(3))
            0: return cv_t'($urandom);
            1: return cv_t'(int'($urandom_range(40)) * VOLT - 20 * VOLT
                            + int'($urandom_range(2)) - 1);
            default: return cv_t'(int'($urandom_range(24 * VOLT)) - 12 * VOLT);
        endcase
    endfunction

    initial
    begin
        knob_set = '{20'd0, 20'd65536, 20'd131071, 20'd32768,
                     20'($urandom_range(131071)), 20'($urandom_range(131071)),
                     20'($urandom), 20'd12345};
        cv_set = '{20'd1, 20'd1, 20'd1, 20'd0, 20'd1, 20'd1, 20'd3, 20'd1};
        rate_set = '{20'd44100, 20'd48000, 20'd768000, 20'd1000, 20'd0, 20'hFFFFF,
                     20'($urandom_range(768000, 1000)), 20'd1};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, control voltage ignored
        send_sample(SMP_HI, CV_HI);
        send_sample(SMP_HI, CV_LO);
        send_sample(SMP_LO, CV_HI);
        send_sample('0, '0);
        send_sample(24'sh555555, CV_LO);
        send_sample(24'shAAAAAA, 24'sh555555);
        send_sample(24'sh000001, 24'shAAAAAA);
        send_sample(24'shFFFFFF, '0);

        drain();
        write_reg(CFG_CUTOFF_KNOB, 20'd65536);
        write_reg(CFG_CV_CONNECTED, 20'd1);
        write_reg(CFG_SAMPLE_RATE, 20'd44100);
        write_reg(CFG_SPARE, 20'hFFFFF);
        send_sample(SMP_HI, CV_HI);
        send_sample(SMP_LO, CV_LO);
        send_sample(SMP_HI, cv_t'(-10 * VOLT));
        send_sample(SMP_LO, cv_t'(-10 * VOLT - 1));
        send_sample(SMP_HI, cv_t'(10 * VOLT));
        send_sample(SMP_LO, cv_t'(10 * VOLT + 1));
        send_sample(SMP_HI, cv_t'(VOLT - 1));
        send_sample('0, '0);
        send_sample(SMP_LO, cv_t'(-1));

        // zero rate, knob data with masked upper bits, cv flag masked off
        drain();
        write_reg(CFG_SAMPLE_RATE, 20'd0);
        write_reg(CFG_CUTOFF_KNOB, 20'hFFFFF);
        write_reg(CFG_CV_CONNECTED, 20'hFFFFE);
        send_sample(SMP_HI, CV_HI);
        send_sample(SMP_LO, CV_LO);
        send_sample(24'sh123456, 24'sh654321);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_rates(p % 4);
            write_reg(CFG_CUTOFF_KNOB, knob_set[p]);
            write_reg(CFG_CV_CONNECTED, cv_set[p]);
            write_reg(CFG_SAMPLE_RATE, rate_set[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && (p == 1 || p == 5))
                    hold_request = 1'b1;
                if (i == PHASE_ITEMS / 2 && (p == 3 || p == 6))
                begin
                    in_valid = 1'b0;
                    while (tracker.pending() != 0)
                        @(negedge clk);
                end
                send_sample(rand_sample(), rand_cv());
            end
        end

        drain();
        repeat (40) @(negedge clk);
        if (tracker.pending() != 0)
            tracker.errors += tracker.pending();
        $display("%0d samples sent, %0d outputs matched, %0d errors", sent,
                 tracker.matched, tracker.errors);
        $display("%0d register writes: rates from zero to full width, knob past one octave",
                 tracker.writes);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/oplpf_pkg.sv
rtl/oplpf_ctrl.sv
rtl/oplpf_dpath.sv
rtl/one_pole_lowpass_exp_cutoff.sv
rtl/oplpf_checker.sv
bench/tb_one_pole_lowpass_exp_cutoff.sv
